// ===== hw/rtl/nns_pkg.sv =====
package nns_pkg;

    // Item field widths
    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;

    // Configuration register widths
    localparam int SRC_W_W    = 10;
    localparam int SRC_H_W    = 9;
    localparam int DST_W_W    = 12;
    localparam int DST_H_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_SRC_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_SRC_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_DST_WIDTH  = 2'd2;
    localparam cfg_idx_t CFG_DST_HEIGHT = 2'd3;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Reset values of the size registers
    localparam logic [SRC_W_W-1:0] SRC_WIDTH_RST  = 10'd640;
    localparam logic [SRC_H_W-1:0] SRC_HEIGHT_RST = 9'd480;
    localparam logic [DST_W_W-1:0] DST_WIDTH_RST  = 12'd640;
    localparam logic [DST_H_W-1:0] DST_HEIGHT_RST = 12'd480;

endpackage

// ===== hw/rtl/nns_in_if.sv =====
interface nns_in_if
    import nns_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;

    modport source (
        output valid, kind, col, row, red_in, green_in, blue_in,
        input  ready
    );

    modport sink (
        input  valid, kind, col, row, red_in, green_in, blue_in,
        output ready
    );
endinterface

// ===== hw/rtl/nns_out_if.sv =====
interface nns_out_if
    import nns_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              in_range;

    modport source (
        output valid, red_out, green_out, blue_out, in_range,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, in_range,
        output ready
    );
endinterface

// ===== hw/rtl/nns_div.sv =====
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits.
module nns_div #(
    parameter int NW = 22,
    parameter int DW = 12,
    parameter int QW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);
    localparam int CW    = (NW > DW + QW) ? NW : DW + QW;
    localparam int CNT_W = $clog2(QW + 1);

    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    dsh_reg, dsh_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             ge;
    logic [CW-1:0]    diff;

    assign ge   = (rem_reg >= dsh_reg);
    assign diff = rem_reg - dsh_reg;

    // Load operands on start, then subtract the shifted divisor where it fits
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = CW'(dividend);
            dsh_next  = CW'(divisor) << (QW - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = QW'({q_reg, ge});
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
endmodule

// ===== hw/rtl/nns_store.sv =====
// Single-port frame memory with registered read data
module nns_store
    import nns_pkg::*;
#(
    parameter int DEPTH = 307200,
    parameter int AW    = 19
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [PIX_W-1:0] wdata,
    output logic [PIX_W-1:0] rdata
);
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/nearest_neighbor_rgb_scaler.sv =====
// Nearest-neighbor RGB scaler over a single-port frame memory.
// in_ch carries items: kind 0 stores red/green/blue at source (col,row),
// ignored outside src_width x src_height (saturated, zero as one); kind 1
// asks for destination (col,row) and yields one item on out_ch with the
// source pixel at (col*src_width/dst_width, row*src_height/dst_height) and
// in_range set, or zeros with in_range clear outside dst_width x dst_height.
// The cfg_we/cfg_idx/cfg_data port writes the four size registers; write
// them only while no item is in flight.
// One item is worked on at a time. A write is stored, and the block is idle
// again before it takes the next item. An in-range read passes S_MUL, S_DIV,
// S_RD and S_LOAD: the bit-serial column and row dividers run in parallel,
// giving XW and YW quotient bits (XW and YW are ceil(log2) of MAX_SRC_WIDTH
// and MAX_SRC_HEIGHT), then one memory read; once the result is loaded the
// block is idle again and takes the next item. An out-of-range read goes
// from S_MUL straight to S_LOAD.
// The result sits in an output register; when the receiver stalls, the
// block holds it and still accepts and stores write items, but stops taking
// items once the next read is waiting to load its result.
// Reset returns the size registers to 640x480 / 640x480 and empties the
// output register; frame memory contents are undefined until written.
module nearest_neighbor_rgb_scaler
    import nns_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = 640,
    parameter int MAX_SRC_HEIGHT = 480
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nns_in_if.sink                in_ch,
    nns_out_if.source             out_ch
);
    localparam int XW    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int YW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PX_W  = COORD_W + SRC_W_W;
    localparam int PY_W  = COORD_W + SRC_H_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_RD   = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [SRC_W_W-1:0]  src_width_reg, src_width_next;
    logic [SRC_H_W-1:0]  src_height_reg, src_height_next;
    logic [DST_W_W-1:0]  dst_width_reg, dst_width_next;
    logic [DST_H_W-1:0]  dst_height_reg, dst_height_next;
    logic                kind_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic                zero_reg, zero_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]    out_pix_reg;
    logic                out_in_range_reg;

    logic [SRC_W_W-1:0]  sw;
    logic [SRC_H_W-1:0]  sh;
    logic                accept;
    logic                wr_hit;
    logic                rd_hit;
    logic [PX_W-1:0]     prod_x;
    logic [PY_W-1:0]     prod_y;
    logic                div_start;
    logic                busy_x;
    logic                busy_y;
    logic [XW-1:0]       qx;
    logic [YW-1:0]       qy;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       mem_addr;
    logic                mem_we;
    logic                mem_re;
    logic [PIX_W-1:0]    mem_rdata;
    logic                out_load;

    // Saturate source size to the frame memory, zero counts as one
    always_comb
    begin
        if (src_width_reg == '0)
        begin
            sw = SRC_W_W'(1);
        end
        else if (32'(src_width_reg) > MAX_SRC_WIDTH)
        begin
            sw = SRC_W_W'(MAX_SRC_WIDTH);
        end
        else
        begin
            sw = src_width_reg;
        end

        if (src_height_reg == '0)
        begin
            sh = SRC_H_W'(1);
        end
        else if (32'(src_height_reg) > MAX_SRC_HEIGHT)
        begin
            sh = SRC_H_W'(MAX_SRC_HEIGHT);
        end
        else
        begin
            sh = src_height_reg;
        end
    end

    // Configuration writes
    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_SRC_WIDTH:  src_width_next  = cfg_data[SRC_W_W-1:0];
                CFG_SRC_HEIGHT: src_height_next = cfg_data[SRC_H_W-1:0];
                CFG_DST_WIDTH:  dst_width_next  = cfg_data[DST_W_W-1:0];
                CFG_DST_HEIGHT: dst_height_next = cfg_data[DST_H_W-1:0];
            endcase
        end
    end

    assign accept = in_ch.valid && in_ch.ready;

    // Bounds checks and scaling products on the captured item
    assign wr_hit = (col_reg < COORD_W'(sw)) && (row_reg < COORD_W'(sh));
    assign rd_hit = (col_reg < dst_width_reg) && (row_reg < dst_height_reg);
    assign prod_x = PX_W'(col_reg) * PX_W'(sw);
    assign prod_y = PY_W'(row_reg) * PY_W'(sh);

    assign div_start = (state_reg == S_MUL) && (kind_reg == KIND_READ) && rd_hit;

    nns_div #(
        .NW (PX_W),
        .DW (DST_W_W),
        .QW (XW)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_x),
        .divisor  (dst_width_reg),
        .busy     (busy_x),
        .quotient (qx)
    );

    nns_div #(
        .NW (PY_W),
        .DW (DST_H_W),
        .QW (YW)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_y),
        .divisor  (dst_height_reg),
        .busy     (busy_y),
        .quotient (qy)
    );

    // Memory addressing: row-major with a fixed pitch of MAX_SRC_WIDTH
    assign wr_addr  = AW'(row_reg[YW-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(col_reg[XW-1:0]);
    assign rd_addr  = AW'(qy) * AW'(MAX_SRC_WIDTH) + AW'(qx);
    assign mem_addr = (state_reg == S_MUL) ? wr_addr : rd_addr;
    assign mem_we   = (state_reg == S_MUL) && (kind_reg == KIND_WRITE) && wr_hit;
    assign mem_re   = (state_reg == S_RD);

    nns_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (pix_reg),
        .rdata (mem_rdata)
    );

    assign out_load = (state_reg == S_LOAD) && (!out_valid_reg || out_ch.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                zero_next = !rd_hit;
                if (kind_reg == KIND_WRITE)
                begin
                    state_next = S_IDLE;
                end
                else if (rd_hit)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_DIV:
            begin
                if (!busy_x && !busy_y)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
            dst_width_reg  <= DST_WIDTH_RST;
            dst_height_reg <= DST_HEIGHT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            dst_width_reg  <= dst_width_next;
            dst_height_reg <= dst_height_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the item and the result payload
    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        if (accept)
        begin
            kind_reg <= in_ch.kind;
            col_reg  <= in_ch.col;
            row_reg  <= in_ch.row;
            pix_reg  <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
        end
        if (out_load)
        begin
            out_pix_reg      <= zero_reg ? '0 : mem_rdata;
            out_in_range_reg <= !zero_reg;
        end
    end

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.red_out   = out_pix_reg[PIX_W-1 -: CHAN_W];
    assign out_ch.green_out = out_pix_reg[CHAN_W +: CHAN_W];
    assign out_ch.blue_out  = out_pix_reg[CHAN_W-1:0];
    assign out_ch.in_range  = out_in_range_reg;
endmodule

// ===== dv/tb_nearest_neighbor_rgb_scaler.sv =====
`timescale 1ns / 1ps

module tb_nearest_neighbor_rgb_scaler;
    import nns_pkg::*;

    localparam int MAX_COLS      = 640;
    localparam int MAX_ROWS      = 480;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int ITEM_TARGET   = 1550;
    localparam int MAX_GAP       = 10;
    localparam int SETTLE_CYCLES = 30;
    localparam int SHOW_LIMIT    = 10;

    typedef struct {
        logic               kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        bit                 drain_first;
    } px_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              in_range;
    } scaled_px_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    nns_in_if  in_ch();
    nns_out_if out_ch();

    nearest_neighbor_rgb_scaler #(
        .MAX_SRC_WIDTH  (MAX_COLS),
        .MAX_SRC_HEIGHT (MAX_ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Size registers as last written
    logic [SRC_W_W-1:0] src_w_reg = SRC_WIDTH_RST;
    logic [SRC_H_W-1:0] src_h_reg = SRC_HEIGHT_RST;
    logic [DST_W_W-1:0] dst_w_reg = DST_WIDTH_RST;
    logic [DST_H_W-1:0] dst_h_reg = DST_HEIGHT_RST;

    // Frame contents as the block should hold them, and pixels the stimulus has lined up
    logic [PIX_W-1:0] frame_px[int unsigned];
    bit               px_planned[int unsigned];
    int unsigned      planned_addrs[$];

    px_item_t   send_q[$];
    scaled_px_t owed_px[$];
    px_item_t   on_wire;
    bit         hold_next;
    bit         send_burst;
    bit         recv_burst;
    int         send_gap;
    int         recv_stall;

    int items_queued;
    int items_taken;
    int work_items;
    int mismatches;
    int results_seen;
    int writes_taken;
    int writes_stored;
    int reads_taken;
    int reads_inside;
    int settings_used = 1;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int unsigned src_cols();
        return clamp_size(src_w_reg, MAX_COLS);
    endfunction

    function automatic int unsigned src_rows();
        return clamp_size(src_h_reg, MAX_ROWS);
    endfunction

    function automatic bit dst_inside(int unsigned col, int unsigned row);
        return col < dst_w_reg && row < dst_h_reg;
    endfunction

    // Nearest source pixel address for a destination coordinate inside the destination
    function automatic int unsigned source_addr(int unsigned col, int unsigned row);
        return ((row * src_rows()) / dst_h_reg) * MAX_COLS + (col * src_cols()) / dst_w_reg;
    endfunction

    // Apply one accepted item to the frame copy; queue the pixel a read owes
    function automatic void take_item(px_item_t it);
        scaled_px_t  res;
        int unsigned addr;
        if (it.kind == KIND_WRITE)
        begin
            writes_taken++;
            if (it.col < src_cols() && it.row < src_rows())
            begin
                frame_px[it.row * MAX_COLS + it.col] = {it.red, it.green, it.blue};
                writes_stored++;
            end
        end
        else
        begin
            reads_taken++;
            res = '0;
            if (dst_inside(it.col, it.row))
            begin
                addr = source_addr(it.col, it.row);
                if (frame_px.exists(addr))
                    {res.red, res.green, res.blue} = frame_px[addr];
                res.in_range = 1'b1;
                reads_inside++;
            end
            owed_px.push_back(res);
        end
    endfunction

    function automatic void log_mismatch(string what, scaled_px_t want, scaled_px_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("%0t: %s: want rgb %02h %02h %02h in_range %b, got rgb %02h %02h %02h in_range %b",
                     $time, what, want.red, want.green, want.blue, want.in_range,
                     got.red, got.green, got.blue, got.in_range);
    endfunction

    function automatic void queue_item(logic kind, int unsigned col, int unsigned row,
                                       logic [PIX_W-1:0] px);
        px_item_t it;
        it.kind        = kind;
        it.col         = COORD_W'(col);
        it.row         = COORD_W'(row);
        it.red         = px[23:16];
        it.green       = px[15:8];
        it.blue        = px[7:0];
        it.drain_first = hold_next;
        hold_next      = 1'b0;
        send_q.push_back(it);
        items_queued++;
    endfunction

    // Line up a pixel write; only writes that land in the source image count as work
    function automatic void queue_write(int unsigned col, int unsigned row, logic [PIX_W-1:0] px);
        int unsigned addr;
        if (col < src_cols() && row < src_rows())
        begin
            addr = row * MAX_COLS + col;
            if (!px_planned.exists(addr))
            begin
                px_planned[addr] = 1'b1;
                planned_addrs.push_back(addr);
            end
            work_items++;
        end
        queue_item(KIND_WRITE, col, row, px);
    endfunction

    function automatic void queue_read(int unsigned col, int unsigned row);
        work_items++;
        queue_item(KIND_READ, col, row, PIX_W'($urandom));
    endfunction

    function automatic bit read_ok(int unsigned col, int unsigned row);
        return !dst_inside(col, row) || px_planned.exists(source_addr(col, row));
    endfunction

    // Pick a read that never lands on an unwritten pixel
    function automatic void queue_random_read();
        int unsigned col;
        int unsigned row;
        int unsigned addr;
        for (int t = 0; t < 16; t++)
        begin
            col = $urandom_range(0, COORD_MAX);
            row = $urandom_range(0, COORD_MAX);
            case ($urandom_range(0, 7))
                0:
                    col = $urandom_range(dst_w_reg, COORD_MAX);
                1:
                    row = $urandom_range(dst_h_reg, COORD_MAX);
                2, 3:
                begin
                    if (dst_w_reg != 0 && dst_h_reg != 0)
                    begin
                        col = $urandom_range(0, dst_w_reg - 1);
                        row = $urandom_range(0, dst_h_reg - 1);
                    end
                end
                default:
                begin
                    // aim at a written pixel through the inverse mapping
                    if (planned_addrs.size() != 0)
                    begin
                        addr = planned_addrs[$urandom_range(0, planned_addrs.size() - 1)];
                        col  = ((addr % MAX_COLS) * dst_w_reg + src_cols() - 1) / src_cols();
                        row  = ((addr / MAX_COLS) * dst_h_reg + src_rows() - 1) / src_rows();
                    end
                end
            endcase
            if (col <= COORD_MAX && row <= COORD_MAX && read_ok(col, row))
            begin
                queue_read(col, row);
                return;
            end
        end
        queue_read(COORD_MAX, COORD_MAX);
    endfunction

    function automatic int unsigned pick_dst(int unsigned s);
        case ($urandom_range(0, 7))
            0:       return s;
            1:       return 1;
            2:       return $urandom_range(3000, COORD_MAX);
            3, 4:    return $urandom_range(1, s);
            default: return $urandom_range(s, 4 * s + 4);
        endcase
    endfunction

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SRC_WIDTH;
        cfg_data <= CFG_DATA_W'(sw);
        @(posedge clk);
        cfg_idx  <= CFG_SRC_HEIGHT;
        cfg_data <= CFG_DATA_W'(sh);
        @(posedge clk);
        cfg_idx  <= CFG_DST_WIDTH;
        cfg_data <= CFG_DATA_W'(dw);
        @(posedge clk);
        cfg_idx  <= CFG_DST_HEIGHT;
        cfg_data <= CFG_DATA_W'(dh);
        @(posedge clk);
        cfg_we   <= 1'b0;
        src_w_reg = SRC_W_W'(sw);
        src_h_reg = SRC_H_W'(sh);
        dst_w_reg = DST_W_W'(dw);
        dst_h_reg = DST_H_W'(dh);
        settings_used++;
    endtask

    // Hold until every item is taken and every owed pixel is back, then let writes settle
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (items_taken != items_queued || owed_px.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Small image written whole, then scanned or sampled with the odd rewrite
    task automatic run_small_phase();
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned n;
        sw = $urandom_range(1, 16);
        sh = $urandom_range(1, 12);
        dw = pick_dst(sw);
        dh = pick_dst(sh);
        set_sizes(sw, sh, dw, dh);
        for (int unsigned r = 0; r < sh; r++)
        begin
            for (int unsigned c = 0; c < sw; c++)
            begin
                if ($urandom_range(0, 19) == 0)
                    queue_write($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                PIX_W'($urandom));
                queue_write(c, r, PIX_W'($urandom));
            end
        end
        if (dw * dh <= 96)
        begin
            for (int unsigned r = 0; r <= dh; r++)
            begin
                for (int unsigned c = 0; c <= dw; c++)
                begin
                    if (r == dh / 2 && c == 0)
                        hold_next = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        queue_write($urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                                    PIX_W'($urandom));
                    queue_read(c, r);
                end
            end
        end
        else
        begin
            n = $urandom_range(30, 80);
            for (int unsigned i = 0; i < n; i++)
            begin
                if (i == n / 2 || $urandom_range(0, 63) == 0)
                    hold_next = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    queue_write($urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                                PIX_W'($urandom));
                queue_random_read();
            end
        end
        wait_quiet();
    endtask

    // Large or saturated source with a few scattered pixels, read back through the mapping
    task automatic run_sparse_phase();
        int unsigned sw;
        int unsigned sh;
        int unsigned ew;
        int unsigned eh;
        int unsigned n;
        case ($urandom_range(0, 3))
            0:
            begin
                sw = MAX_COLS;
                sh = MAX_ROWS;
            end
            1:
            begin
                sw = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_COLS + 1, 1023);
                sh = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_ROWS + 1, 511);
            end
            default:
            begin
                sw = $urandom_range(17, MAX_COLS);
                sh = $urandom_range(13, MAX_ROWS);
            end
        endcase
        ew = clamp_size(sw, MAX_COLS);
        eh = clamp_size(sh, MAX_ROWS);
        set_sizes(sw, sh, pick_dst(ew), pick_dst(eh));
        queue_write(0, 0, PIX_W'($urandom));
        queue_write(ew - 1, eh - 1, PIX_W'($urandom));
        n = $urandom_range(20, 40);
        repeat (n)
            queue_write($urandom_range(0, ew - 1), $urandom_range(0, eh - 1), PIX_W'($urandom));
        n = $urandom_range(30, 60);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i == n / 2)
                hold_next = 1'b1;
            if ($urandom_range(0, 9) == 0)
                queue_write($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                            PIX_W'($urandom));
            queue_random_read();
        end
        wait_quiet();
    endtask

    // Input side: present queued items with random gaps, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.kind     <= KIND_WRITE;
            in_ch.col      <= '0;
            in_ch.row      <= '0;
            in_ch.red_in   <= '0;
            in_ch.green_in <= '0;
            in_ch.blue_in  <= '0;
            send_gap       <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
            begin
                take_item(on_wire);
                items_taken++;
            end
            if (send_gap != 0)
            begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (send_q.size() != 0 && !(send_q[0].drain_first && owed_px.size() != 0))
            begin
                on_wire = send_q.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.kind     <= on_wire.kind;
                in_ch.col      <= on_wire.col;
                in_ch.row      <= on_wire.row;
                in_ch.red_in   <= on_wire.red;
                in_ch.green_in <= on_wire.green;
                in_ch.blue_in  <= on_wire.blue;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output side: stall at random, check each pixel against the oldest owed one
    always @(posedge clk or negedge rst_n)
    begin : take_results
        scaled_px_t want;
        scaled_px_t got;
        int         stall;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end
        else
        begin
            stall = recv_stall;
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                got = {out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.in_range};
                if (owed_px.size() == 0)
                begin
                    log_mismatch("pixel with no read waiting", '0, got);
                end
                else
                begin
                    want = owed_px.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.in_range !== want.in_range)
                        log_mismatch("pixel mismatch", want, got);
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                recv_stall   <= stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                recv_stall   <= 0;
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_SRC_WIDTH;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = KIND_WRITE;
        in_ch.col      = '0;
        in_ch.row      = '0;
        in_ch.red_in   = '0;
        in_ch.green_in = '0;
        in_ch.blue_in  = '0;
        out_ch.ready   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: corners, edges and far-off coordinates, then an overwrite
        queue_write(0, 0, 24'hFF_FF_FF);
        queue_write(MAX_COLS - 1, MAX_ROWS - 1, 24'h00_00_00);
        queue_write(1, 0, 24'hA5_5A_C3);
        queue_write(MAX_COLS, 0, PIX_W'($urandom));
        queue_write(0, MAX_ROWS, PIX_W'($urandom));
        queue_write(COORD_MAX, COORD_MAX, 24'hFF_FF_FF);
        queue_read(0, 0);
        queue_read(MAX_COLS - 1, MAX_ROWS - 1);
        queue_read(1, 0);
        queue_read(MAX_COLS, 0);
        queue_read(0, MAX_ROWS);
        queue_read(COORD_MAX, COORD_MAX);
        queue_write(0, 0, 24'h12_34_56);
        queue_read(0, 0);
        wait_quiet();

        // Single-pixel destination
        set_sizes(MAX_COLS, MAX_ROWS, 1, 1);
        queue_read(0, 0);
        queue_read(1, 0);
        wait_quiet();

        // Largest destination
        set_sizes(MAX_COLS, MAX_ROWS, COORD_MAX, COORD_MAX);
        queue_read(COORD_MAX - 1, COORD_MAX - 1);
        queue_read(0, 0);
        queue_read(COORD_MAX, 0);
        wait_quiet();

        // Zero destination size: every read falls outside
        set_sizes(MAX_COLS, MAX_ROWS, 0, 0);
        queue_read(0, 0);
        wait_quiet();

        // Oversized source saturates to the frame size
        set_sizes(1023, 511, MAX_COLS, MAX_ROWS);
        queue_write(MAX_COLS - 1, MAX_ROWS - 1, PIX_W'($urandom));
        queue_write(MAX_COLS, 0, PIX_W'($urandom));
        queue_read(MAX_COLS - 1, MAX_ROWS - 1);
        wait_quiet();

        // Zero source size behaves as one pixel
        set_sizes(0, 0, 2, 2);
        queue_write(0, 0, PIX_W'($urandom));
        queue_write(1, 0, PIX_W'($urandom));
        queue_read(1, 1);
        wait_quiet();

        while (work_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
                run_sparse_phase();
            else
                run_small_phase();
        end

        wait_quiet();
        $display("Covered %0d pixel writes (%0d stored) and %0d reads (%0d inside the destination)",
                 writes_taken, writes_stored, reads_taken, reads_inside);
        $display("over %0d size settings; %0d pixels checked, %0d mismatches",
                 settings_used, results_seen, mismatches);
        if (mismatches == 0 && owed_px.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(8_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
